>>> sv/vlmf_pkg.sv
// Shared types and constants for the variable-length message FIFO.
// Used by the queue stage, the execution stage, the top level and the checker.
package vlmf_pkg;

    localparam int STORE_WORDS = 1024;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam logic [12:0] MAX_CAP   = 13'(STORE_WORDS * 4 > 4096 ? 4096 : STORE_WORDS * 4);
    localparam logic [13:0] HDR_BYTES = 14'd4;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_STATUS = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEN  = 3'd1,
        ST_FULL     = 3'd2,
        ST_NEVER    = 3'd3,
        ST_REJ_WORD = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef enum logic {
        CFG_CAPACITY = 1'b0,
        CFG_DISCARD  = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DROPCHK,
        S_DROP,
        S_FIT,
        S_PUSH2,
        S_PHDR,
        S_PDATA,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [12:0] msg_length;
        logic [31:0] data_word;
    } item_t;

endpackage

>>> sv/vlmf_front.sv
// Front queue: two-entry buffer that accepts input transfers.
// Depends on vlmf_pkg for the item type.
module vlmf_front
    import vlmf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  q_valid,
    input  logic  q_ready,
    output item_t q_item
);

    item_t       ent_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> sv/vlmf_back.sv
// Execution stage: message store, ring pointers, drop-oldest walk, pop unit
// and output register. Depends on vlmf_pkg.
module vlmf_back
    import vlmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_status,
    output logic [31:0] out_word,
    output logic [11:0] out_plen,
    output logic        out_last,
    output logic [12:0] out_used,
    output logic [12:0] out_free,
    output logic        out_has
);

    logic [31:0] mem [STORE_WORDS];
    logic [31:0] rd_data_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [31:0]       mem_wdata;

    state_t state_reg, state_next;
    item_t  cur_reg, cur_next;
    logic [12:0] cap_reg, cap_next;
    logic        disc_reg, disc_next;
    logic [ADDR_W-1:0] head_reg, head_next, commit_reg, commit_next, wi_reg, wi_next;
    logic [12:0] occ_reg, occ_next;
    logic [10:0] cnt_reg, cnt_next;
    logic [10:0] pushl_reg, pushl_next;
    logic        rej_reg, rej_next;
    logic [10:0] popl_reg, popl_next;
    logic [12:0] plen_reg, plen_next;
    logic [2:0]  rs_reg, rs_next;
    logic [31:0] rw_reg, rw_next;
    logic        rl_reg, rl_next;
    logic [11:0] rp_reg, rp_next;
    logic        ov_reg, ov_next;
    logic [2:0]  os_reg;
    logic [31:0] ow_reg;
    logic [11:0] op_reg;
    logic        ol_reg;
    logic [12:0] ou_reg, of_reg;
    logic        oh_reg;
    logic        load_out;

    logic [12:0] eff_cap;
    logic [11:0] words;
    logic [13:0] size;
    logic        no_fit;
    logic        drop_en;
    logic [12:0] drop_len;
    logic [11:0] drop_words;
    logic [13:0] drop_size;
    logic [11:0] pop_total, pop_pos;
    logic [14:0] free_full;

    assign eff_cap = (cap_reg > MAX_CAP) ? MAX_CAP : cap_reg;
    assign words   = 12'((14'(cur_reg.msg_length) + 14'd3) >> 2);
    assign size    = {words, 2'b00} + HDR_BYTES;
    assign no_fit  = (15'(occ_reg) + 15'(size)) > 15'(eff_cap);
    assign pop_total = 12'((14'(plen_reg) + 14'd3) >> 2);
    assign pop_pos   = pop_total - 12'(popl_reg);
    assign drop_words = 12'((14'(drop_len) + 14'd3) >> 2);
    assign drop_size  = {drop_words, 2'b00} + HDR_BYTES;

    assign q_ready  = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_RESP) && (!ov_reg || out_ready);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (q_valid) state_next = S_DECODE;
            S_DECODE:
            begin
                state_next = S_RESP;
                case (cur_reg.mode)
                    MODE_PUSH:
                    begin
                        if (pushl_reg == 11'd0 && cur_reg.msg_length != 13'd0
                            && cur_reg.msg_length <= eff_cap)
                        begin
                            if (!disc_reg)
                            begin
                                state_next = S_FIT;
                            end
                            else if (size <= 14'(eff_cap))
                            begin
                                state_next = S_DROPCHK;
                            end
                        end
                    end
                    MODE_POP:
                    begin
                        if (popl_reg != 11'd0)
                        begin
                            state_next = S_PDATA;
                        end
                        else if (cnt_reg != 11'd0)
                        begin
                            state_next = S_PHDR;
                        end
                    end
                    default: state_next = S_RESP;
                endcase
            end
            S_DROPCHK: state_next = (no_fit && cnt_reg != 11'd0) ? S_DROP : S_FIT;
            S_DROP:    state_next = S_DROPCHK;
            S_FIT:     state_next = no_fit ? S_RESP : S_PUSH2;
            S_PUSH2:   state_next = S_RESP;
            S_PHDR:    state_next = (rd_data_reg[12:0] == 13'd0) ? S_RESP : S_PDATA;
            S_PDATA:   state_next = S_RESP;
            S_RESP:    if (load_out) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cur_next = cur_reg;  cap_next = cap_reg;  disc_next = disc_reg;
        head_next = head_reg; commit_next = commit_reg; wi_next = wi_reg;
        occ_next = occ_reg;  cnt_next = cnt_reg;
        pushl_next = pushl_reg; rej_next = rej_reg;
        popl_next = popl_reg;   plen_next = plen_reg;
        rs_next = rs_reg; rw_next = rw_reg; rl_next = rl_reg; rp_next = rp_reg;
        mem_we = 1'b0; mem_waddr = wi_reg; mem_wdata = cur_reg.data_word;
        mem_re = 1'b0; mem_raddr = head_reg;
        drop_en = 1'b0; drop_len = rd_data_reg[12:0];

        if (cfg_we)
        begin
            if (cfg_index == CFG_CAPACITY)
            begin
                cap_next = cfg_data;
            end
            else
            begin
                disc_next = cfg_data[0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                cur_next = q_item;
                rs_next  = ST_OK;
                rw_next  = 32'd0;
                rl_next  = 1'b0;
                rp_next  = 12'd0;
            end
            S_DECODE:
            begin
                case (cur_reg.mode)
                    MODE_PUSH:
                    begin
                        if (pushl_reg != 11'd0)
                        begin
                            pushl_next = pushl_reg - 11'd1;
                            if (rej_reg)
                            begin
                                rs_next = ST_REJ_WORD;
                            end
                            else
                            begin
                                mem_we  = 1'b1;
                                wi_next = wi_reg + ADDR_W'(1);
                                if (pushl_reg == 11'd1)
                                begin
                                    commit_next = wi_reg + ADDR_W'(1);
                                    cnt_next    = cnt_reg + 11'd1;
                                end
                            end
                        end
                        else if (cur_reg.msg_length == 13'd0 || cur_reg.msg_length > eff_cap)
                        begin
                            rs_next    = ST_BAD_LEN;
                            rej_next   = 1'b1;
                            pushl_next = (words == 12'd0) ? 11'd0 : 11'(words - 12'd1);
                        end
                        else if (disc_reg && size > 14'(eff_cap))
                        begin
                            rs_next    = ST_NEVER;
                            rej_next   = 1'b1;
                            pushl_next = 11'(words - 12'd1);
                        end
                    end
                    MODE_POP:
                    begin
                        if (popl_reg != 11'd0)
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = head_reg + ADDR_W'(12'd1 + pop_pos);
                        end
                        else if (cnt_reg == 11'd0)
                        begin
                            rs_next = ST_EMPTY;
                        end
                        else
                        begin
                            mem_re = 1'b1;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        head_next = '0; commit_next = '0; wi_next = '0;
                        occ_next = '0;  cnt_next = '0;
                        pushl_next = '0; rej_next = 1'b0;
                        popl_next = '0;  plen_next = '0;
                    end
                    default: rs_next = ST_OK;
                endcase
            end
            S_DROPCHK:
            begin
                mem_re = 1'b1;
            end
            S_DROP:
            begin
                drop_en = 1'b1;
            end
            S_FIT:
            begin
                pushl_next = 11'(words - 12'd1);
                if (no_fit)
                begin
                    rs_next  = ST_FULL;
                    rej_next = 1'b1;
                end
                else
                begin
                    rej_next  = 1'b0;
                    mem_we    = 1'b1;
                    mem_waddr = commit_reg;
                    mem_wdata = 32'(cur_reg.msg_length);
                    wi_next   = commit_reg + ADDR_W'(1);
                    occ_next  = occ_reg + 13'(size);
                end
            end
            S_PUSH2:
            begin
                mem_we  = 1'b1;
                wi_next = wi_reg + ADDR_W'(1);
                if (pushl_reg == 11'd0)
                begin
                    commit_next = wi_reg + ADDR_W'(1);
                    cnt_next    = cnt_reg + 11'd1;
                end
            end
            S_PHDR:
            begin
                plen_next = rd_data_reg[12:0];
                popl_next = 11'(drop_words);
                if (rd_data_reg[12:0] == 13'd0)
                begin
                    rs_next = ST_EMPTY;
                    drop_en = 1'b1;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = head_reg + ADDR_W'(1);
                end
            end
            S_PDATA:
            begin
                rw_next = rd_data_reg;
                // length is captured here, before the last word releases the message
                rp_next = plen_reg[11:0];
                if (popl_reg == 11'd1)
                begin
                    case (plen_reg[1:0])
                        2'd1:    rw_next = {24'd0, rd_data_reg[7:0]};
                        2'd2:    rw_next = {16'd0, rd_data_reg[15:0]};
                        2'd3:    rw_next = {8'd0, rd_data_reg[23:0]};
                        default: rw_next = rd_data_reg;
                    endcase
                    rl_next  = 1'b1;
                    drop_en  = 1'b1;
                    drop_len = plen_reg;
                end
                else
                begin
                    popl_next = popl_reg - 11'd1;
                end
            end
            default: rs_next = rs_reg;
        endcase

        // remove the head message; any pop in progress is cancelled
        if (drop_en)
        begin
            head_next = head_reg + ADDR_W'(drop_words + 12'd1);
            occ_next  = (14'(occ_reg) >= drop_size) ? 13'(14'(occ_reg) - drop_size) : 13'd0;
            if (cnt_reg != 11'd0)
            begin
                cnt_next = cnt_reg - 11'd1;
            end
            popl_next = '0;
            plen_next = '0;
        end
    end

    assign free_full = 15'(eff_cap) - 15'(occ_reg) - 15'd4;

    always_comb
    begin
        ov_next = ov_reg;
        if (out_valid && out_ready)
        begin
            ov_next = 1'b0;
        end
        if (load_out)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        rs_reg  <= rs_next;
        rw_reg  <= rw_next;
        rl_reg  <= rl_next;
        rp_reg  <= rp_next;
        if (load_out)
        begin
            os_reg <= rs_reg;
            ow_reg <= rw_reg;
            op_reg <= (rs_reg == ST_OK) ? rp_reg : 12'd0;
            ol_reg <= rl_reg;
            ou_reg <= occ_reg;
            of_reg <= ($signed(free_full) < -15'sd4096) ? 13'h1000 : free_full[12:0];
            oh_reg <= (cnt_reg != 11'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg <= 13'd4096; disc_reg <= 1'b0;
            head_reg <= '0; commit_reg <= '0; wi_reg <= '0;
            occ_reg <= '0; cnt_reg <= '0;
            pushl_reg <= '0; rej_reg <= 1'b0;
            popl_reg <= '0; plen_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg <= cap_next; disc_reg <= disc_next;
            head_reg <= head_next; commit_reg <= commit_next; wi_reg <= wi_next;
            occ_reg <= occ_next; cnt_reg <= cnt_next;
            pushl_reg <= pushl_next; rej_reg <= rej_next;
            popl_reg <= popl_next; plen_reg <= plen_next;
            ov_reg <= ov_next;
        end
    end

    assign out_valid  = ov_reg;
    assign out_status = os_reg;
    assign out_word   = ow_reg;
    assign out_plen   = op_reg;
    assign out_last   = ol_reg;
    assign out_used   = ou_reg;
    assign out_free   = of_reg;
    assign out_has    = oh_reg;

endmodule

>>> sv/variable_length_message_fifo.sv
// Top level of the variable-length message FIFO: front queue plus execution stage.
// Depends on vlmf_pkg, vlmf_front and vlmf_back.
//
//  channel | direction | signals                         | payload
//  s       | in        | s_tvalid s_tready s_tdata s_tuser | command word
//  m       | out       | m_tvalid m_tready m_tdata m_tuser m_tlast | result
//  cfg     | in        | cfg_we cfg_index cfg_data       | register write
//
// Status, clear and rejected/continuation push words go straight from decode to
// the response; a pop word also reads the store (registered store read), a first push
// word with discard on reads one header per dropped message. The
// execution stage works on one item at a time; the two-entry front queue keeps
// accepting until full; the output register holds a result while m_tready is low.
// rst_n clears all pointers and counters; store contents are not cleared.
module variable_length_message_fifo
    import vlmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // msg_length[12:0], data_word[44:13], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // data_word_res[31:0], msg_length_res[43:32],
                                   // used_bytes[56:44], free_bytes[69:57],
                                   // has_message[70], zero pad
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    item_t in_item, q_item;
    logic  q_valid, q_ready;
    logic [31:0] o_word;
    logic [11:0] o_plen;
    logic [12:0] o_used, o_free;
    logic        o_has;

    assign in_item.mode       = s_tuser;
    assign in_item.msg_length = s_tdata[12:0];
    assign in_item.data_word  = s_tdata[44:13];

    vlmf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    vlmf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_word   (o_word),
        .out_plen   (o_plen),
        .out_last   (m_tlast),
        .out_used   (o_used),
        .out_free   (o_free),
        .out_has    (o_has)
    );

    assign m_tdata = {1'b0, o_has, o_free, o_used, o_plen, o_word};

endmodule

>>> sv/vlmf_checker.sv
// Port-level checker for the variable-length message FIFO, bound to the top.
// Depends on vlmf_pkg for status codes.
module vlmf_checker
    import vlmf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> !m_tlast && m_tdata[43:0] == 44'd0)
        else $error("failed step carries pop data");

    a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[56:44] <= 13'd4096)
        else $error("used bytes above store size");

    a_last_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[43:32] != 12'd0)
        else $error("last word without message length");

endmodule

bind variable_length_message_fifo vlmf_checker u_vlmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
